// ----- hw/rtl/svt_pkg.sv -----
`timescale 1ns / 1ps

package svt_pkg;

    // Field widths of one section key
    localparam int TABLE_ID_W       = 8;
    localparam int SERVICE_ID_W     = 16;
    localparam int STREAM_ID_W      = 16;
    localparam int SECTION_NUMBER_W = 8;
    localparam int VERSION_W        = 5;
    localparam int KEY_W            = TABLE_ID_W + SERVICE_ID_W + STREAM_ID_W
                                      + SECTION_NUMBER_W;

    // One stored table entry
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [VERSION_W-1:0] version;
    } t_entry;

endpackage

// ----- hw/rtl/section_version_tracker.sv -----
`timescale 1ns / 1ps
// Each input transaction is compared against the stored entries, at most ENTRIES of them;
//   the table is scanned one entry per cycle through one memory read port.
// o_ready is low while a scan runs and until the result is loaded into the output register.
// Reset: synchronous, active low; clears the entry count and all control state.
//   Table contents are not cleared; entries above the count are never read.
module section_version_tracker
    import svt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [TABLE_ID_W-1:0]       i_table_id,
    input  logic [SERVICE_ID_W-1:0]     i_service_id,
    input  logic [STREAM_ID_W-1:0]      i_stream_id,
    input  logic [SECTION_NUMBER_W-1:0] i_section_number,
    input  logic [VERSION_W-1:0]        i_version,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_seen,
    output logic                        o_added,
    output logic                        o_dropped
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state             r_state,     n_state;
    logic [KEY_W-1:0]   r_key,       n_key;
    logic [VERSION_W-1:0] r_ver,     n_ver;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic [CNT_W-1:0]   r_idx,       n_idx;
    logic               r_cmp_vld,   n_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx,   n_cmp_idx;
    logic               r_res_seen,  n_res_seen;
    logic               r_res_added, n_res_added;
    logic               r_res_drop,  n_res_drop;
    logic               r_out_valid, n_out_valid;
    logic               r_seen,      n_seen;
    logic               r_added,     n_added;
    logic               r_dropped,   n_dropped;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    t_entry           mem_wr_data;
    logic             mem_rd_en;
    t_entry           mem_rd_data;
    logic             hit;
    logic             full;

    assign hit  = r_cmp_vld && (mem_rd_data.key == r_key);
    assign full = (r_count == CNT_W'(ENTRIES));

    // Sequence the scan and the result hand-off
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_ver       = r_ver;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_res_seen  = r_res_seen;
        n_res_added = r_res_added;
        n_res_drop  = r_res_drop;
        n_out_valid = r_out_valid && !i_ready;
        n_seen      = r_seen;
        n_added     = r_added;
        n_dropped   = r_dropped;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_count[IDX_W-1:0];
        mem_wr_data = '{key: r_key, version: r_ver};
        mem_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Capture the key of a new transaction
                if (i_valid) begin
                    n_key   = {i_table_id, i_service_id, i_stream_id, i_section_number};
                    n_ver   = i_version;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (hit) begin
                    // Update the version of the matching entry
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_cmp_idx;
                    n_res_seen  = (mem_rd_data.version == r_ver);
                    n_res_added = 1'b0;
                    n_res_drop  = 1'b0;
                    n_state     = S_HOLD;
                end else if (r_idx != r_count) begin
                    // Advance to the next stored entry
                    mem_rd_en = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end else begin
                    // Append an unknown key, or drop it when full
                    mem_wr_en   = !full;
                    n_count     = full ? r_count : r_count + 1'b1;
                    n_res_seen  = 1'b0;
                    n_res_added = !full;
                    n_res_drop  = full;
                    n_state     = S_HOLD;
                end
            end
            S_HOLD: begin
                // Load the output register once it is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_seen      = r_res_seen;
                    n_added     = r_res_added;
                    n_dropped   = r_res_drop;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
        r_key       <= n_key;
        r_ver       <= n_ver;
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_res_seen  <= n_res_seen;
        r_res_added <= n_res_added;
        r_res_drop  <= n_res_drop;
        r_seen      <= n_seen;
        r_added     <= n_added;
        r_dropped   <= n_dropped;
    end

    svt_mem #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (mem_rd_data)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_seen    = r_seen;
    assign o_added   = r_added;
    assign o_dropped = r_dropped;

endmodule

// ----- hw/rtl/svt_mem.sv -----
`timescale 1ns / 1ps

module svt_mem
    import svt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/svt_checker.sv -----
`timescale 1ns / 1ps

module svt_checker
    import svt_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [TABLE_ID_W-1:0]       i_table_id,
    input logic [SERVICE_ID_W-1:0]     i_service_id,
    input logic [STREAM_ID_W-1:0]      i_stream_id,
    input logic [SECTION_NUMBER_W-1:0] i_section_number,
    input logic [VERSION_W-1:0]        i_version,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_seen,
    input logic                        o_added,
    input logic                        o_dropped
);

    // At most one outcome flag per result
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_seen, o_added, o_dropped}) <= 1)
        else $error("more than one outcome flag set");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable({o_seen, o_added, o_dropped})))
        else $error("stalled result changed");

    // Hold a waiting input transaction
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable({i_table_id, i_service_id,
                                                       i_stream_id, i_section_number,
                                                       i_version})))
        else $error("waiting input changed");

    // Drop ready after an accepted input transaction while the scan runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held during scan");

    // Clear the output on reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind section_version_tracker svt_checker u_svt_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import svt_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int DIR_ROWS       = 19;
    localparam int RANDOM_ITEMS   = 880;
    localparam int IDLE_PCT       = 34;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTS     = 100;

    // One received section key plus its version
    typedef struct {
        logic [TABLE_ID_W-1:0]       table_id;
        logic [SERVICE_ID_W-1:0]     service_id;
        logic [STREAM_ID_W-1:0]      stream_id;
        logic [SECTION_NUMBER_W-1:0] section_number;
        logic [VERSION_W-1:0]        version;
    } t_section;

    // Outcome of one lookup
    typedef struct {
        logic seen;
        logic added;
        logic dropped;
    } t_verdict;

    // Directed stimulus row; typed rows carry their own expected verdict
    typedef struct {
        t_section sec;
        bit       typed;
        t_verdict want;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [TABLE_ID_W-1:0]       i_table_id = '0;
    logic [SERVICE_ID_W-1:0]     i_service_id = '0;
    logic [STREAM_ID_W-1:0]      i_stream_id = '0;
    logic [SECTION_NUMBER_W-1:0] i_section_number = '0;
    logic [VERSION_W-1:0]        i_version = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic                        o_seen;
    logic                        o_added;
    logic                        o_dropped;

    // Shadow copy of the section table
    logic [KEY_W-1:0]     known_key [TABLE_DEPTH];
    logic [VERSION_W-1:0] known_ver [TABLE_DEPTH];
    int                   known_count = 0;

    t_verdict verdict_q [$];
    t_dir_row dir_rows [DIR_ROWS];

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int error_count = 0;
    int stall_cycles = 0;
    int n_seen = 0;
    int n_added = 0;
    int n_dropped = 0;
    int n_renewed = 0;

    section_version_tracker #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_table_id      (i_table_id),
        .i_service_id    (i_service_id),
        .i_stream_id     (i_stream_id),
        .i_section_number(i_section_number),
        .i_version       (i_version),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_seen          (o_seen),
        .o_added         (o_added),
        .o_dropped       (o_dropped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [KEY_W-1:0] key_of(input t_section s);
        return {s.table_id, s.service_id, s.stream_id, s.section_number};
    endfunction

    function automatic t_section split_key(input logic [KEY_W-1:0] k,
                                           input logic [VERSION_W-1:0] ver);
        t_section s;
        {s.table_id, s.service_id, s.stream_id, s.section_number} = k;
        s.version = ver;
        return s;
    endfunction

    function automatic t_dir_row mk_row(input logic [KEY_W-1:0] k,
                                        input int ver,
                                        input int typed, input int seen,
                                        input int added, input int dropped);
        t_dir_row r;
        r.sec   = split_key(k, VERSION_W'(ver));
        r.typed = (typed != 0);
        r.want  = '{seen != 0, added != 0, dropped != 0};
        return r;
    endfunction

    // Scan the shadow table in arrival order and update it like the block does
    function automatic t_verdict lookup_section(input t_section s);
        logic [KEY_W-1:0] k;
        t_verdict v;
        k = key_of(s);
        v = '{1'b0, 1'b0, 1'b0};
        for (int i = 0; i < known_count; i++) begin
            if (known_key[i] == k) begin
                v.seen = (known_ver[i] == s.version);
                known_ver[i] = s.version;
                return v;
            end
        end
        if (known_count < TABLE_DEPTH) begin
            known_key[known_count] = k;
            known_ver[known_count] = s.version;
            known_count++;
            v.added = 1'b1;
        end else begin
            v.dropped = 1'b1;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Offer one transaction, with random idle cycles ahead of it; call at a falling edge
    task automatic push_section(input t_section s, input bit typed, input t_verdict want);
        t_verdict v;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_table_id       <= s.table_id;
        i_service_id     <= s.service_id;
        i_stream_id      <= s.stream_id;
        i_section_number <= s.section_number;
        i_version        <= s.version;
        do @(posedge i_clk); while (!o_ready);
        v = lookup_section(s);
        verdict_q.push_back(typed ? want : v);
        @(negedge i_clk);
    endtask

    // Receiver: random backpressure, one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result seen=%b added=%b dropped=%b",
                                          o_seen, o_added, o_dropped));
            end else begin
                want = verdict_q.pop_front();
                if (o_seen !== want.seen)
                    report_mismatch($sformatf("seen: got %b want %b", o_seen, want.seen));
                if (o_added !== want.added)
                    report_mismatch($sformatf("added: got %b want %b", o_added, want.added));
                if (o_dropped !== want.dropped)
                    report_mismatch($sformatf("dropped: got %b want %b",
                                              o_dropped, want.dropped));
                if (want.seen)
                    n_seen++;
                else if (want.added)
                    n_added++;
                else if (want.dropped)
                    n_dropped++;
                else
                    n_renewed++;
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("section_version_tracker regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_section                 s;
        t_verdict                 none;
        int                       pick;
        int                       idx;
        logic [KEY_W-1:0]         one_hot;

        none    = '{1'b0, 1'b0, 1'b0};
        one_hot = {{(KEY_W-1){1'b0}}, 1'b1};

        // Directed rows: empty key, full key, single-field keys, version changes
        dir_rows = '{
            mk_row(48'h0000_0000_0000,  0, 1, 0, 1, 0),
            mk_row(48'h0000_0000_0000,  0, 1, 1, 0, 0),
            mk_row(48'h0000_0000_0000, 31, 1, 0, 0, 0),
            mk_row(48'h0000_0000_0000, 31, 1, 1, 0, 0),
            mk_row(48'hFFFF_FFFF_FFFF, 31, 1, 0, 1, 0),
            mk_row(48'hFFFF_FFFF_FFFF,  0, 1, 0, 0, 0),
            mk_row(48'hFFFF_FFFF_FFFF,  0, 1, 1, 0, 0),
            mk_row(48'hFF00_0000_0000,  5, 1, 0, 1, 0),
            mk_row(48'h00FF_FF00_0000, 10, 1, 0, 1, 0),
            mk_row(48'h0000_00FF_FF00, 20, 1, 0, 1, 0),
            mk_row(48'h0000_0000_00FF, 30, 1, 0, 1, 0),
            mk_row(48'hA55A_5AA5_A55A, 21, 0, 0, 0, 0),
            mk_row(48'h5AA5_A55A_5AA5, 10, 0, 0, 0, 0),
            mk_row(48'h0000_0000_0000, 31, 0, 0, 0, 0),
            mk_row(48'hA55A_5AA5_A55A, 21, 0, 0, 0, 0),
            mk_row(48'hA55A_5AA5_A55A, 20, 0, 0, 0, 0),
            mk_row(48'hFF00_0000_0000,  5, 0, 0, 0, 0),
            mk_row(48'hFFFF_FFFF_FFFE, 31, 0, 0, 0, 0),
            mk_row(48'hFFFF_FFFF_FFFF,  0, 0, 0, 0, 0)
        };

        // Hold reset, release at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            push_section(dir_rows[r].sec, dir_rows[r].typed, dir_rows[r].want);

        // Random part: repeats of stored keys, one-bit near misses, fresh keys
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200)
                hold_req = 1'b1;
            if (n == 450) begin
                // Drain everything before offering more
                i_valid <= 1'b0;
                do @(negedge i_clk); while (verdict_q.size() != 0);
            end
            calm = (n >= 600 && n < 750);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                idx = $urandom_range(0, known_count - 1);
                s = split_key(known_key[idx],
                              $urandom_range(0, 1) ? known_ver[idx]
                                                   : VERSION_W'($urandom_range(0, 31)));
            end else if (pick < 50) begin
                idx = $urandom_range(0, known_count - 1);
                s = split_key(known_key[idx] ^ (one_hot << $urandom_range(0, KEY_W - 1)),
                              VERSION_W'($urandom_range(0, 31)));
            end else begin
                s.table_id       = TABLE_ID_W'($urandom_range(0, 255));
                s.service_id     = SERVICE_ID_W'($urandom_range(0, 65535));
                s.stream_id      = STREAM_ID_W'($urandom_range(0, 65535));
                s.section_number = SECTION_NUMBER_W'($urandom_range(0, 255));
                s.version        = VERSION_W'($urandom_range(0, 31));
            end
            push_section(s, 1'b0, none);
        end
        i_valid <= 1'b0;

        // Wait for the last results, then let the block settle
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        $display("covered %0d sections: %0d seen, %0d added, %0d dropped, %0d version updates",
                 n_seen + n_added + n_dropped + n_renewed,
                 n_seen, n_added, n_dropped, n_renewed);
        $display("table ended with %0d of %0d entries; %0d mismatches",
                 known_count, TABLE_DEPTH, error_count);
        if (error_count == 0) begin
            $display("section_version_tracker regression: pass");
        end else begin
            $display("section_version_tracker regression: fail");
        end
        $finish;
    end

endmodule
